// ----- rtl/brf_pkg.sv -----
`timescale 1ns / 1ps
// Package for the byte ring FIFO with delimited pop.
// Holds operation codes and parameter defaults; no dependencies.
package brf_pkg;

    localparam int DEPTH_DEF   = 256;
    localparam int MAX_RUN_DEF = 64;

    typedef enum logic [1:0] {
        FUNC_PUSH      = 2'd0,
        FUNC_POP       = 2'd1,
        FUNC_POP_UNTIL = 2'd2,
        FUNC_NOP       = 2'd3
    } func_t;

endpackage

// ----- rtl/byte_ring_fifo_delimited_pop.sv -----
`timescale 1ns / 1ps
// Byte ring FIFO top level: push, counted pop and pop-until-delimiter.
// Depends on brf_pkg for operation codes and parameter defaults.
//
//  channel | direction | ports
//  --------+-----------+---------------------------------------------------------
//  s_      | in        | s_valid s_ready s_func s_data_byte s_delimiter s_max_count
//  m_      | out       | m_valid m_ready m_out_byte m_byte_valid m_last
//          |           | m_found_delim m_accepted m_fill_level m_high_water
//
// One item at a time, all through a single-port byte memory (one read or one write
// per cycle, read data registered). Push, no-op and empty pop: accept, execute,
// result. Pop of N bytes: accept, execute, then one result beat per byte. Pop-until:
// a scan reads bytes from the head up to the delimiter or the count, then emits them.
// Output stalls hold the result register and pause the byte run.
// Reset (aresetn low, synchronous) empties the FIFO and clears the high-water mark.
module byte_ring_fifo_delimited_pop #(
    parameter int DEPTH   = brf_pkg::DEPTH_DEF,
    parameter int MAX_RUN = brf_pkg::MAX_RUN_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  brf_pkg::func_t      s_func,
    input  logic [7:0]          s_data_byte,
    input  logic [7:0]          s_delimiter,
    input  logic [6:0]          s_max_count,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_byte_valid,
    output logic                m_last,
    output logic                m_found_delim,
    output logic                m_accepted,
    output logic [7:0]          m_fill_level,
    output logic [7:0]          m_high_water
);
    import brf_pkg::*;

    localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int RUN_W = (MAX_RUN > 1) ? $clog2(MAX_RUN + 1) : 1;
    localparam int CMP_W = (PTR_W > RUN_W) ? PTR_W : RUN_W;
    localparam int LVL_W = (PTR_W > 8) ? PTR_W : 8;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EXEC   = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_EMIT   = 5'b01000,
        ST_SINGLE = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    func_t              func_reg;
    logic [7:0]         data_reg;
    logic [7:0]         delim_reg;
    logic [RUN_W-1:0]   cnt_reg;
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [PTR_W-1:0]   level_reg, level_next;
    logic [PTR_W-1:0]   peak_reg, peak_next;
    logic               acc_reg, acc_next;
    logic               found_reg, found_next;
    logic [RUN_W-1:0]   rem_reg, rem_next;
    logic [RUN_W-1:0]   lim_reg, lim_next;
    logic [RUN_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [PTR_W-1:0]   scan_ptr_reg, scan_ptr_next;

    logic [7:0]         mem [DEPTH];
    logic [7:0]         rd_data_reg;
    logic               rd_en;
    logic [PTR_W-1:0]   rd_addr;
    logic               wr_en;

    logic               m_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               out_bvalid_reg;
    logic               out_last_reg;
    logic               out_found_reg;
    logic               out_acc_reg;
    logic [7:0]         out_fill_reg;
    logic [7:0]         out_hw_reg;

    logic               out_load;
    logic               out_free;
    logic [7:0]         ld_byte;
    logic               ld_bvalid;
    logic               ld_last;
    logic               ld_found;
    logic               ld_acc;

    logic [CMP_W-1:0]   level_ext;
    logic [CMP_W-1:0]   cnt_ext;
    logic [RUN_W-1:0]   lim;
    logic               full;
    logic [PTR_W-1:0]   wptr_inc;
    logic [PTR_W-1:0]   rptr_inc;
    logic [PTR_W-1:0]   scan_inc;
    logic [PTR_W-1:0]   push_level;
    logic [RUN_W-1:0]   take;
    logic [LVL_W-1:0]   level_wide;
    logic [LVL_W-1:0]   peak_wide;
    logic [RUN_W-1:0]   cnt_in;

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    assign wptr_inc = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
    assign rptr_inc = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
    assign scan_inc = (scan_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : scan_ptr_reg + 1'b1;

    assign full       = (level_reg == PTR_W'(DEPTH - 1));
    assign push_level = full ? level_reg : level_reg + 1'b1;
    assign level_ext  = CMP_W'(level_reg);
    assign cnt_ext    = CMP_W'(cnt_reg);
    assign lim        = (level_ext < cnt_ext) ? level_ext[RUN_W-1:0] : cnt_reg;

    // Counts above the run limit saturate
    assign cnt_in = (s_max_count > 7'(MAX_RUN)) ? RUN_W'(MAX_RUN)
                                                 : s_max_count[RUN_W-1:0];

    always_comb begin
        state_next    = state_reg;
        wptr_next     = wptr_reg;
        rptr_next     = rptr_reg;
        level_next    = level_reg;
        peak_next     = peak_reg;
        acc_next      = acc_reg;
        found_next    = found_reg;
        rem_next      = rem_reg;
        lim_next      = lim_reg;
        scan_idx_next = scan_idx_reg;
        scan_ptr_next = scan_ptr_reg;
        rd_en         = 1'b0;
        rd_addr       = rptr_reg;
        wr_en         = 1'b0;
        out_load      = 1'b0;
        ld_byte       = '0;
        ld_bvalid     = 1'b0;
        ld_last       = 1'b1;
        ld_found      = 1'b0;
        ld_acc        = 1'b0;
        take          = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                acc_next   = 1'b0;
                found_next = 1'b0;
                lim_next   = lim;
                unique case (func_reg)
                    FUNC_PUSH: begin
                        if (!full) begin
                            wr_en     = 1'b1;
                            wptr_next = wptr_inc;
                            acc_next  = 1'b1;
                        end
                        level_next = push_level;
                        if (push_level > peak_reg) begin
                            peak_next = push_level;
                        end
                        state_next = ST_SINGLE;
                    end
                    FUNC_POP: begin
                        if (lim == '0) begin
                            state_next = ST_SINGLE;
                        end else begin
                            take       = lim;
                            rem_next   = lim;
                            level_next = PTR_W'(level_ext - CMP_W'(take));
                            rd_en      = 1'b1;
                            state_next = ST_EMIT;
                        end
                    end
                    FUNC_POP_UNTIL: begin
                        if (lim == '0) begin
                            state_next = ST_SINGLE;
                        end else begin
                            scan_idx_next = '0;
                            scan_ptr_next = rptr_reg;
                            rd_en         = 1'b1;
                            state_next    = ST_SCAN;
                        end
                    end
                    FUNC_NOP: begin
                        state_next = ST_SINGLE;
                    end
                    default: begin
                        state_next = ST_SINGLE;
                    end
                endcase
            end
            ST_SCAN: begin
                // rd_data_reg holds the byte at scan_ptr_reg
                if (rd_data_reg == delim_reg) begin
                    take       = scan_idx_reg + 1'b1;
                    found_next = 1'b1;
                end else if (RUN_W'(scan_idx_reg + 1'b1) == lim_reg) begin
                    take       = lim_reg;
                    found_next = 1'b0;
                end
                if (take != '0) begin
                    // restart reads at the head for the run
                    rem_next   = take;
                    level_next = PTR_W'(level_ext - CMP_W'(take));
                    rd_en      = 1'b1;
                    rd_addr    = rptr_reg;
                    state_next = ST_EMIT;
                end else begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                    scan_ptr_next = scan_inc;
                    rd_en         = 1'b1;
                    rd_addr       = scan_inc;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    ld_byte   = rd_data_reg;
                    ld_bvalid = 1'b1;
                    ld_last   = (rem_reg == RUN_W'(1));
                    ld_found  = found_reg;
                    rptr_next = rptr_inc;
                    if (rem_reg == RUN_W'(1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        rem_next = rem_reg - 1'b1;
                        rd_en    = 1'b1;
                        rd_addr  = rptr_inc;
                    end
                end
            end
            ST_SINGLE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    ld_acc     = acc_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Byte store: one port, read data registered and held between reads
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wptr_reg] <= data_reg;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Fields of the accepted item
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg  <= s_func;
            data_reg  <= s_data_byte;
            delim_reg <= s_delimiter;
            cnt_reg   <= cnt_in;
        end
        acc_reg      <= acc_next;
        found_reg    <= found_next;
        rem_reg      <= rem_next;
        lim_reg      <= lim_next;
        scan_idx_reg <= scan_idx_next;
        scan_ptr_reg <= scan_ptr_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            level_reg <= '0;
            peak_reg  <= '0;
        end else begin
            state_reg <= state_next;
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            level_reg <= level_next;
            peak_reg  <= peak_next;
        end
    end

    assign level_wide = LVL_W'(level_reg);
    assign peak_wide  = LVL_W'(peak_reg);

    // Result register; level and peak are already final when a beat loads
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_byte_reg   <= ld_byte;
            out_bvalid_reg <= ld_bvalid;
            out_last_reg   <= ld_last;
            out_found_reg  <= ld_found;
            out_acc_reg    <= ld_acc;
            out_fill_reg   <= (level_wide > LVL_W'(255)) ? 8'hFF : level_wide[7:0];
            out_hw_reg     <= (peak_wide > LVL_W'(255)) ? 8'hFF : peak_wide[7:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = out_byte_reg;
    assign m_byte_valid  = out_bvalid_reg;
    assign m_last        = out_last_reg;
    assign m_found_delim = out_found_reg;
    assign m_accepted    = out_acc_reg;
    assign m_fill_level  = out_fill_reg;
    assign m_high_water  = out_hw_reg;

endmodule
